// ----- hw/rtl/wavhp_pkg.sv -----
// ----------------------------------------------------------------------------
// wavhp_pkg
// Shared widths, result codes, chunk tags and word types of the WAV parser.
// ----------------------------------------------------------------------------
package wavhp_pkg;

   localparam int unsigned LEN_W  = 31;
   localparam int unsigned RATE_W = 32;

   // result kinds
   localparam logic [1:0] KIND_AUDIO  = 2'd0;
   localparam logic [1:0] KIND_HEADER = 2'd1;
   localparam logic [1:0] KIND_ERROR  = 2'd2;

   // error codes
   localparam logic [3:0] ERR_NONE      = 4'd0;
   localparam logic [3:0] ERR_TRUNCATED = 4'd1;
   localparam logic [3:0] ERR_NO_RIFF   = 4'd2;
   localparam logic [3:0] ERR_NO_WAVE   = 4'd3;
   localparam logic [3:0] ERR_NO_FMT    = 4'd4;
   localparam logic [3:0] ERR_FMT_SHORT = 4'd5;
   localparam logic [3:0] ERR_NO_DATA   = 4'd6;
   localparam logic [3:0] ERR_EMPTY     = 4'd7;
   localparam logic [3:0] ERR_TOO_LARGE = 4'd8;
   localparam logic [3:0] ERR_BAD_CHAN  = 4'd9;

   // little-endian four-character tags
   localparam logic [31:0] TAG_RIFF = 32'h4646_4952;
   localparam logic [31:0] TAG_WAVE = 32'h4556_4157;
   localparam logic [31:0] TAG_FMT  = 32'h2074_6d66;
   localparam logic [31:0] TAG_DATA = 32'h6174_6164;

   localparam logic [15:0] PCM_TAG      = 16'h0001;
   localparam logic [31:0] FMT_MIN_SIZE = 32'd16;
   localparam logic [15:0] PAD_BYTES    = 16'd6;

   // register index of file_length
   localparam logic REG_FILE_LENGTH = 1'b0;

   typedef struct packed {
      logic       vld;
      logic [7:0] data;
   } in_word_type;

   typedef struct packed {
      logic [1:0]        kind;
      logic [7:0]        audio_byte;
      logic [RATE_W-1:0] sample_rate;
      logic [1:0]        channel_count;
      logic [15:0]       sample_bits;
      logic [15:0]       format_code;
      logic [LEN_W-1:0]  payload_size;
      logic [3:0]        error_code;
      logic              final_byte;
   } rsp_word_type;

endpackage

// ----- hw/rtl/wavhp_if.sv -----
// ----------------------------------------------------------------------------
// wavhp_byte_if / wavhp_rsp_if
// Valid/ready channels for file bytes in and parser results out.
// ----------------------------------------------------------------------------
interface wavhp_byte_if;
   logic       valid;
   logic       ready;
   logic [7:0] data_byte;

   modport source (output valid, output data_byte, input ready);
   modport sink (input valid, input data_byte, output ready);
endinterface

interface wavhp_rsp_if;
   logic                          valid;
   logic                          ready;
   logic [1:0]                    kind;
   logic [7:0]                    audio_byte;
   logic [wavhp_pkg::RATE_W-1:0]  sample_rate;
   logic [1:0]                    channel_count;
   logic [15:0]                   sample_bits;
   logic [15:0]                   format_code;
   logic [wavhp_pkg::LEN_W-1:0]   payload_size;
   logic [3:0]                    error_code;
   logic                          final_byte;

   modport source (output valid, output kind, output audio_byte, output sample_rate,
                   output channel_count, output sample_bits, output format_code,
                   output payload_size, output error_code, output final_byte,
                   input ready);
   modport sink (input valid, input kind, input audio_byte, input sample_rate,
                 input channel_count, input sample_bits, input format_code,
                 input payload_size, input error_code, input final_byte,
                 output ready);
endinterface

// ----- hw/rtl/wavhp_csr.sv -----
// ----------------------------------------------------------------------------
// wavhp_csr
// APB register file holding the file length.
// ----------------------------------------------------------------------------
module wavhp_csr (
   input  logic                        clock,
   input  logic                        reset,
   input  logic                        csr_psel,
   input  logic                        csr_penable,
   input  logic                        csr_pwrite,
   input  logic [2:0]                  csr_paddr,
   input  logic [31:0]                 csr_pwdata,
   output logic [31:0]                 csr_prdata,
   output logic                        csr_pready,
   output logic [wavhp_pkg::LEN_W-1:0] file_length
);

   logic [wavhp_pkg::LEN_W-1:0] file_length_ff;
   logic [wavhp_pkg::LEN_W-1:0] file_length_in;
   logic                        wr_hit;

   assign wr_hit = csr_psel && csr_penable && csr_pwrite
                   && (csr_paddr[2] == wavhp_pkg::REG_FILE_LENGTH);

   always_comb begin
      file_length_in = file_length_ff;
      if (wr_hit) begin
         file_length_in = csr_pwdata[wavhp_pkg::LEN_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         file_length_ff <= '0;
      end else begin
         file_length_ff <= file_length_in;
      end
   end

   assign csr_pready  = 1'b1;
   assign csr_prdata  = (csr_paddr[2] == wavhp_pkg::REG_FILE_LENGTH)
                        ? {1'b0, file_length_ff} : 32'd0;
   assign file_length = file_length_ff;

endmodule

// ----- hw/rtl/wavhp_in_stage.sv -----
// ----------------------------------------------------------------------------
// wavhp_in_stage
// Input register for file bytes; refills in the cycle the parser takes one.
// ----------------------------------------------------------------------------
module wavhp_in_stage (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   input  logic [7:0]             req_data,
   output logic                   req_ready,
   input  logic                   take,
   output wavhp_pkg::in_word_type word
);

   logic       vld_ff;
   logic       vld_in;
   logic [7:0] data_ff;
   logic [7:0] data_in;
   logic       accept;

   assign req_ready = !vld_ff || take;
   assign accept    = req_valid && req_ready;

   always_comb begin
      vld_in  = vld_ff;
      data_in = data_ff;
      if (accept) begin
         vld_in  = 1'b1;
         data_in = req_data;
      end else if (take) begin
         vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= 1'b0;
      end else begin
         vld_ff <= vld_in;
      end
      data_ff <= data_in;
   end

   assign word.vld  = vld_ff;
   assign word.data = data_ff;

endmodule

// ----- hw/rtl/wavhp_parse.sv -----
// ----------------------------------------------------------------------------
// wavhp_parse
// Header state machine, one byte per cycle while the result register is not stalled, with the result register.
// ----------------------------------------------------------------------------
module wavhp_parse (
   input  logic                         clock,
   input  logic                         reset,
   input  wavhp_pkg::in_word_type       word,
   output logic                         take,
   input  logic [wavhp_pkg::LEN_W-1:0]  file_length,
   output logic                         rsp_valid,
   input  logic                         rsp_ready,
   output wavhp_pkg::rsp_word_type      rsp
);

   typedef enum logic [3:0] {
      PH_RIFF, PH_RSIZE, PH_WAVE, PH_FMT, PH_FSIZE, PH_TAG, PH_CH, PH_RATE,
      PH_PAD, PH_BITS, PH_XLEN, PH_SKIP, PH_DTAG, PH_DSIZE, PH_PAYLOAD, PH_IDLE
   } phase_type;

   function automatic logic [2:0] field_len(input phase_type ph);
      logic [2:0] len;
      case (ph)
         PH_TAG, PH_CH, PH_BITS, PH_XLEN: len = 3'd2;
         PH_PAD, PH_SKIP, PH_PAYLOAD, PH_IDLE: len = 3'd0;
         default: len = 3'd4;
      endcase
      return len;
   endfunction

   phase_type                   phase_ff, phase_in;
   logic [31:0]                 cnt_ff, cnt_in;       // byte position + 1
   logic [31:0]                 shift_ff, shift_in;
   logic [1:0]                  idx_ff, idx_in;
   logic                        match_ff, match_in;
   logic [15:0]                 fmt_ff, fmt_in;
   logic [15:0]                 chan_ff, chan_in;
   logic [31:0]                 rate_ff, rate_in;
   logic [15:0]                 bits_ff, bits_in;
   logic [15:0]                 skip_ff, skip_in;
   logic [wavhp_pkg::LEN_W-1:0] pay_ff, pay_in;
   logic                        rsp_vld_ff, rsp_vld_in;
   wavhp_pkg::rsp_word_type     rsp_ff, rsp_in;

   logic                        last;
   logic [31:0]                 v;
   logic                        too_large;
   logic                        emit;
   wavhp_pkg::rsp_word_type     res;

   assign take = word.vld && (!rsp_vld_ff || rsp_ready);
   assign last = cnt_ff >= {1'b0, file_length};
   assign v    = shift_ff | ({24'd0, word.data} << {idx_ff, 3'b000});
   // v above the bytes left after the size word
   assign too_large = ({1'b0, v} + {1'b0, cnt_ff}) > {2'b00, file_length};

   always_comb begin
      phase_in = phase_ff;
      cnt_in   = cnt_ff;
      shift_in = shift_ff;
      idx_in   = idx_ff;
      match_in = match_ff;
      fmt_in   = fmt_ff;
      chan_in  = chan_ff;
      rate_in  = rate_ff;
      bits_in  = bits_ff;
      skip_in  = skip_ff;
      pay_in   = pay_ff;
      emit     = 1'b0;
      res      = '0;

      case (phase_ff)
         PH_PAYLOAD: begin
            emit           = 1'b1;
            res.kind       = wavhp_pkg::KIND_AUDIO;
            res.audio_byte = word.data;
            res.final_byte = (pay_ff == wavhp_pkg::LEN_W'(1));
            pay_in         = pay_ff - wavhp_pkg::LEN_W'(1);
            if (pay_ff == wavhp_pkg::LEN_W'(1)) begin
               phase_in = PH_IDLE;
            end
         end
         PH_IDLE: begin
         end
         PH_PAD, PH_SKIP: begin
            skip_in = skip_ff - 16'd1;
            if (skip_ff == 16'd1) begin
               phase_in = (phase_ff == PH_PAD) ? PH_BITS : PH_DTAG;
            end
         end
         default: begin
            if (({1'b0, idx_ff} + 3'd1) < field_len(phase_ff)) begin
               shift_in = v;
               idx_in   = idx_ff + 2'd1;
            end else begin
               shift_in = '0;
               idx_in   = '0;
               case (phase_ff)
                  PH_RIFF: begin
                     match_in = (v == wavhp_pkg::TAG_RIFF);
                     phase_in = PH_RSIZE;
                  end
                  PH_RSIZE: begin
                     if (!match_ff) begin
                        emit = 1'b1;
                        res.error_code = wavhp_pkg::ERR_NO_RIFF;
                     end else begin
                        phase_in = PH_WAVE;
                     end
                  end
                  PH_WAVE: begin
                     if (v != wavhp_pkg::TAG_WAVE) begin
                        emit = 1'b1;
                        res.error_code = wavhp_pkg::ERR_NO_WAVE;
                     end else begin
                        phase_in = PH_FMT;
                     end
                  end
                  PH_FMT: begin
                     match_in = (v == wavhp_pkg::TAG_FMT);
                     phase_in = PH_FSIZE;
                  end
                  PH_FSIZE: begin
                     if (!match_ff) begin
                        emit = 1'b1;
                        res.error_code = wavhp_pkg::ERR_NO_FMT;
                     end else if (v < wavhp_pkg::FMT_MIN_SIZE) begin
                        emit = 1'b1;
                        res.error_code = wavhp_pkg::ERR_FMT_SHORT;
                     end else begin
                        phase_in = PH_TAG;
                     end
                  end
                  PH_TAG: begin
                     fmt_in   = v[15:0];
                     phase_in = PH_CH;
                  end
                  PH_CH: begin
                     chan_in  = v[15:0];
                     phase_in = PH_RATE;
                  end
                  PH_RATE: begin
                     rate_in  = v;
                     skip_in  = wavhp_pkg::PAD_BYTES;
                     phase_in = PH_PAD;
                  end
                  PH_BITS: begin
                     bits_in  = v[15:0];
                     phase_in = (fmt_ff == wavhp_pkg::PCM_TAG) ? PH_DTAG : PH_XLEN;
                  end
                  PH_XLEN: begin
                     skip_in  = v[15:0];
                     phase_in = (v[15:0] == 16'd0) ? PH_DTAG : PH_SKIP;
                  end
                  PH_DTAG: begin
                     match_in = (v == wavhp_pkg::TAG_DATA);
                     phase_in = PH_DSIZE;
                  end
                  PH_DSIZE: begin
                     emit = 1'b1;
                     if (!match_ff) begin
                        res.error_code = wavhp_pkg::ERR_NO_DATA;
                     end else if (v == 32'd0) begin
                        res.error_code = wavhp_pkg::ERR_EMPTY;
                     end else if (too_large) begin
                        res.error_code = wavhp_pkg::ERR_TOO_LARGE;
                     end else if ((chan_ff != 16'd1) && (chan_ff != 16'd2)) begin
                        res.error_code = wavhp_pkg::ERR_BAD_CHAN;
                     end else begin
                        pay_in            = v[wavhp_pkg::LEN_W-1:0];
                        res.kind          = wavhp_pkg::KIND_HEADER;
                        res.sample_rate   = rate_ff;
                        res.channel_count = chan_ff[1:0];
                        res.sample_bits   = bits_ff;
                        res.format_code   = fmt_ff;
                        res.payload_size  = v[wavhp_pkg::LEN_W-1:0];
                        phase_in          = PH_PAYLOAD;
                     end
                  end
                  default: begin
                     phase_in = PH_IDLE;
                  end
               endcase
               // any error code set above ends the file
               if (res.error_code != wavhp_pkg::ERR_NONE) begin
                  res.kind = wavhp_pkg::KIND_ERROR;
                  phase_in = PH_IDLE;
               end
            end
         end
      endcase

      // last byte before the header completes
      if (!emit && last && (phase_in != PH_PAYLOAD) && (phase_in != PH_IDLE)) begin
         emit           = 1'b1;
         res            = '0;
         res.kind       = wavhp_pkg::KIND_ERROR;
         res.error_code = wavhp_pkg::ERR_TRUNCATED;
      end

      // rearm after the last byte of the file
      if (last) begin
         phase_in = PH_RIFF;
         cnt_in   = 32'd1;
         shift_in = '0;
         idx_in   = '0;
         match_in = 1'b0;
         fmt_in   = '0;
         chan_in  = '0;
         rate_in  = '0;
         bits_in  = '0;
         skip_in  = '0;
         pay_in   = '0;
      end else begin
         cnt_in = cnt_ff + 32'd1;
      end
   end

   always_comb begin
      rsp_vld_in = rsp_vld_ff;
      rsp_in     = rsp_ff;
      if (take) begin
         rsp_vld_in = emit;
         rsp_in     = res;
      end else if (rsp_ready) begin
         rsp_vld_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff   <= PH_RIFF;
         cnt_ff     <= 32'd1;
         shift_ff   <= '0;
         idx_ff     <= '0;
         match_ff   <= 1'b0;
         fmt_ff     <= '0;
         chan_ff    <= '0;
         rate_ff    <= '0;
         bits_ff    <= '0;
         skip_ff    <= '0;
         pay_ff     <= '0;
         rsp_vld_ff <= 1'b0;
      end else if (take) begin
         phase_ff   <= phase_in;
         cnt_ff     <= cnt_in;
         shift_ff   <= shift_in;
         idx_ff     <= idx_in;
         match_ff   <= match_in;
         fmt_ff     <= fmt_in;
         chan_ff    <= chan_in;
         rate_ff    <= rate_in;
         bits_ff    <= bits_in;
         skip_ff    <= skip_in;
         pay_ff     <= pay_in;
         rsp_vld_ff <= rsp_vld_in;
      end else begin
         rsp_vld_ff <= rsp_vld_in;
      end
      rsp_ff <= rsp_in;
   end

   assign rsp_valid = rsp_vld_ff;
   assign rsp       = rsp_ff;

endmodule

// ----- hw/rtl/wav_header_parser.sv -----
// A byte passes the input register, then the result register, on its way to rsp_if.
// Throughput: one byte per cycle unless rsp_if stalls; one state machine step per byte.
// The input register refills in the cycle the parser takes its word; a stalled result
// holds the parser and the byte waiting in the input register, and req_if.ready drops.
// Reset (synchronous, active high) rearms the parser and clears file_length to 0.
// ----------------------------------------------------------------------------
// wav_header_parser
// RIFF/WAVE header parser: checks the chunk tags, extracts the format fields,
// then streams the data chunk bytes.
// ----------------------------------------------------------------------------
module wav_header_parser (
   input  logic                  clock,
   input  logic                  reset,
   wavhp_byte_if.sink            req_if,
   wavhp_rsp_if.source           rsp_if,
   input  logic                  csr_psel,
   input  logic                  csr_penable,
   input  logic                  csr_pwrite,
   input  logic [2:0]            csr_paddr,
   input  logic [31:0]           csr_pwdata,
   output logic [31:0]           csr_prdata,
   output logic                  csr_pready
);

   logic [wavhp_pkg::LEN_W-1:0] file_length;
   wavhp_pkg::in_word_type      in_word;
   logic                        take;
   wavhp_pkg::rsp_word_type     rsp_word;
   logic                        rsp_valid;

   // file length register; write only while no file is in flight
   wavhp_csr u_csr (
      .clock       (clock),
      .reset       (reset),
      .csr_psel    (csr_psel),
      .csr_penable (csr_penable),
      .csr_pwrite  (csr_pwrite),
      .csr_paddr   (csr_paddr),
      .csr_pwdata  (csr_pwdata),
      .csr_prdata  (csr_prdata),
      .csr_pready  (csr_pready),
      .file_length (file_length)
   );

   // hold the incoming word until the parser takes it
   wavhp_in_stage u_in (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_if.valid),
      .req_data  (req_if.data_byte),
      .req_ready (req_if.ready),
      .take      (take),
      .word      (in_word)
   );

   // advance the header state machine one byte and register the result word
   wavhp_parse u_parse (
      .clock       (clock),
      .reset       (reset),
      .word        (in_word),
      .take        (take),
      .file_length (file_length),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_if.ready),
      .rsp         (rsp_word)
   );

   // drive the result channel straight from the result register
   assign rsp_if.valid         = rsp_valid;
   assign rsp_if.kind          = rsp_word.kind;
   assign rsp_if.audio_byte    = rsp_word.audio_byte;
   assign rsp_if.sample_rate   = rsp_word.sample_rate;
   assign rsp_if.channel_count = rsp_word.channel_count;
   assign rsp_if.sample_bits   = rsp_word.sample_bits;
   assign rsp_if.format_code   = rsp_word.format_code;
   assign rsp_if.payload_size  = rsp_word.payload_size;
   assign rsp_if.error_code    = rsp_word.error_code;
   assign rsp_if.final_byte    = rsp_word.final_byte;

endmodule

// ----- hw/rtl/wavhp_checker.sv -----
// ----------------------------------------------------------------------------
// wavhp_checker
// Port-level checks on the parser's result channel, bound to the top level.
// ----------------------------------------------------------------------------
module wavhp_checker (
   input logic                        clock,
   input logic                        reset,
   input logic                        rsp_valid,
   input logic                        rsp_ready,
   input logic [1:0]                  kind,
   input logic [1:0]                  channel_count,
   input logic [wavhp_pkg::LEN_W-1:0] payload_size,
   input logic [3:0]                  error_code,
   input logic                        final_byte,
   input logic [7:0]                  audio_byte
);

   // no result in the cycle after reset
   a_idle_after_reset: assert property (@(posedge clock)
      $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // stalled result holds
   a_hold: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=> (rsp_valid && $stable(kind) && $stable(audio_byte)
                                     && $stable(error_code) && $stable(final_byte)))
      else $error("stalled result changed");

   // header words carry a legal channel count, a nonzero payload size and no error code
   a_header: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (kind == wavhp_pkg::KIND_HEADER))
      |-> (((channel_count == 2'd1) || (channel_count == 2'd2))
           && (payload_size != '0) && (error_code == wavhp_pkg::ERR_NONE)))
      else $error("bad header word");

   // error words carry a code in range and never a final flag
   a_error: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && (kind == wavhp_pkg::KIND_ERROR))
      |-> ((error_code != wavhp_pkg::ERR_NONE) && (error_code <= wavhp_pkg::ERR_BAD_CHAN)
           && !final_byte))
      else $error("bad error word");

   // only audio, header or error kinds appear
   a_kind: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> ((kind == wavhp_pkg::KIND_AUDIO) || (kind == wavhp_pkg::KIND_HEADER)
                     || (kind == wavhp_pkg::KIND_ERROR)))
      else $error("unknown result kind");

endmodule

bind wav_header_parser wavhp_checker u_wavhp_checker (
   .clock         (clock),
   .reset         (reset),
   .rsp_valid     (rsp_if.valid),
   .rsp_ready     (rsp_if.ready),
   .kind          (rsp_if.kind),
   .channel_count (rsp_if.channel_count),
   .payload_size  (rsp_if.payload_size),
   .error_code    (rsp_if.error_code),
   .final_byte    (rsp_if.final_byte),
   .audio_byte    (rsp_if.audio_byte)
);
